// File: rtl/lsb_two_bit_extract_defines.svh
// Assertion macros shared by the lsb_two_bit_extract RTL.
`ifndef LSB_TWO_BIT_EXTRACT_DEFINES_SVH
`define LSB_TWO_BIT_EXTRACT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LBE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LBE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lbe_pkg.sv
// Package: types and constants of the two-bit LSB extractor.
`timescale 1ns / 1ps
package lbe_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned LEN_W  = 32;
  localparam int unsigned PAYLOAD_W = 8;

  // header is 16 pairs, payload byte is 4 pairs
  localparam logic [4:0] HEADER_PAIRS    = 5'd16;
  localparam logic [4:0] HEADER_LAST_PC  = 5'd15;
  localparam logic [1:0] LAST_PAIR_IN_BYTE = 2'd3;

  // result_kind codes
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // result buffer: two entries
  localparam logic [1:0] OBUF_FULL = 2'd2;

  typedef struct packed {
    logic              start;
    logic [CHAN_W-1:0] chan;
  } item_t;

  typedef struct packed {
    logic                 kind;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     length;
    logic                 last;
  } res_t;

endpackage

// File: rtl/lbe_in_stage.sv
// Input register stage: holds one accepted beat for the extractor.
`timescale 1ns / 1ps
module lbe_in_stage
  import lbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAN_W-1:0] in_tdata,   // [7:0] channel_byte
  input  logic              in_tuser,   // [0] image_start
  input  logic              take_i,
  output logic              valid_o,
  output item_t             item_o
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_tready = !valid_r || take_i;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
      if (in_tvalid) begin
        item_nxt.start = in_tuser;
        item_nxt.chan  = in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

// File: rtl/lbe_extract.sv
// Extraction state and result logic: header assembly, payload bytes, end detect.
`timescale 1ns / 1ps
`include "lsb_two_bit_extract_defines.svh"
module lbe_extract
  import lbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire_i,
  input  item_t item_i,
  output logic  push_o,
  output res_t  res_o
);

  logic [4:0]       pair_count_r, pair_count_nxt;
  logic [LEN_W-1:0] header_shift_r, header_shift_nxt;
  logic [LEN_W-1:0] length_r, length_nxt;
  logic [5:0]       byte_shift_r, byte_shift_nxt;
  logic [1:0]       pair_in_byte_r, pair_in_byte_nxt;
  logic [LEN_W-1:0] bytes_done_r, bytes_done_nxt;
  logic             finished_r, finished_nxt;

  // state as seen after an image-start clear
  logic [4:0]       pc_e;
  logic [LEN_W-1:0] hs_e, len_e, bd_e;
  logic [5:0]       bs_e;
  logic [1:0]       pib_e;
  logic             fin_e;
  logic [1:0]       pair;

  assign pair = item_i.chan[1:0];

  always_comb begin
    pc_e  = item_i.start ? '0 : pair_count_r;
    hs_e  = item_i.start ? '0 : header_shift_r;
    len_e = item_i.start ? '0 : length_r;
    bs_e  = item_i.start ? '0 : byte_shift_r;
    pib_e = item_i.start ? '0 : pair_in_byte_r;
    bd_e  = item_i.start ? '0 : bytes_done_r;
    fin_e = item_i.start ? 1'b0 : finished_r;

    pair_count_nxt   = pair_count_r;
    header_shift_nxt = header_shift_r;
    length_nxt       = length_r;
    byte_shift_nxt   = byte_shift_r;
    pair_in_byte_nxt = pair_in_byte_r;
    bytes_done_nxt   = bytes_done_r;
    finished_nxt     = finished_r;

    push_o        = 1'b0;
    res_o.kind    = KIND_HEADER;
    res_o.payload = '0;
    res_o.length  = len_e;
    res_o.last    = 1'b0;

    if (fire_i) begin
      pair_count_nxt   = pc_e;
      header_shift_nxt = hs_e;
      length_nxt       = len_e;
      byte_shift_nxt   = bs_e;
      pair_in_byte_nxt = pib_e;
      bytes_done_nxt   = bd_e;
      finished_nxt     = fin_e;

      if (!fin_e) begin
        if (pc_e < HEADER_PAIRS) begin
          header_shift_nxt = {hs_e[LEN_W-3:0], pair};
          pair_count_nxt   = pc_e + 5'd1;
          if (pc_e == HEADER_LAST_PC) begin
            // header complete: announce length; zero length ends here
            length_nxt   = {hs_e[LEN_W-3:0], pair};
            finished_nxt = ({hs_e[LEN_W-3:0], pair} == '0);
            push_o       = 1'b1;
            res_o.kind   = KIND_HEADER;
            res_o.length = {hs_e[LEN_W-3:0], pair};
            res_o.last   = ({hs_e[LEN_W-3:0], pair} == '0);
          end
        end else if (pib_e != LAST_PAIR_IN_BYTE) begin
          byte_shift_nxt   = {bs_e[3:0], pair};
          pair_in_byte_nxt = pib_e + 2'd1;
        end else begin
          byte_shift_nxt   = '0;
          pair_in_byte_nxt = '0;
          bytes_done_nxt   = bd_e + 32'd1;
          finished_nxt     = ((bd_e + 32'd1) == len_e);
          push_o           = 1'b1;
          res_o.kind       = KIND_PAYLOAD;
          res_o.payload    = {bs_e, pair};
          res_o.last       = ((bd_e + 32'd1) == len_e);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_count_r   <= '0;
      header_shift_r <= '0;
      length_r       <= '0;
      byte_shift_r   <= '0;
      pair_in_byte_r <= '0;
      bytes_done_r   <= '0;
      finished_r     <= 1'b0;
    end else begin
      pair_count_r   <= pair_count_nxt;
      header_shift_r <= header_shift_nxt;
      length_r       <= length_nxt;
      byte_shift_r   <= byte_shift_nxt;
      pair_in_byte_r <= pair_in_byte_nxt;
      bytes_done_r   <= bytes_done_nxt;
      finished_r     <= finished_nxt;
    end
  end

  `LBE_ASSERT_NOW(a_pc_range, 1'b1, pair_count_r <= HEADER_PAIRS, "header pair count overrun")
  `LBE_ASSERT_NOW(a_fin_after_hdr, finished_r, pair_count_r == HEADER_PAIRS, "finished before header done")
  `LBE_ASSERT_NOW(a_no_bytes_in_hdr, pair_count_r != HEADER_PAIRS, bytes_done_r == '0 && pair_in_byte_r == '0, "payload progress during header")
  `LBE_ASSERT_NEXT(a_idle_hold, !fire_i && !finished_r, !finished_r, "finished changed without a beat")

endmodule

// File: rtl/lbe_out_buf.sv
// Two-entry result buffer driving the master-side stream.
`timescale 1ns / 1ps
`include "lsb_two_bit_extract_defines.svh"
module lbe_out_buf
  import lbe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  res_t                       res_i,
  output logic                       full_o,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [LEN_W+PAYLOAD_W-1:0] out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  res_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  res_t       head;

  assign full_o     = (count_r == OBUF_FULL);
  assign out_tvalid = (count_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= res_i;
    end
  end

  assign out_tdata = {head.length, head.payload};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  `LBE_ASSERT_NOW(a_cnt_range, 1'b1, count_r <= OBUF_FULL, "result buffer count overrun")
  `LBE_ASSERT_NOW(a_no_push_full, push_i, !full_o, "result pushed into full buffer")
  `LBE_ASSERT_NEXT(a_cnt_track, push_i && !pop, count_r == $past(count_r) + 2'd1, "count missed a push")

endmodule

// File: rtl/lsb_two_bit_extract.sv
// A held beat passes the extractor when the result buffer has room; its result is registered there for out_*.
// Throughput: one input beat per cycle; in_tready drops only when the input
//   register is full and the two-entry result buffer is full, even if the
//   held beat gives no result.
// Beats that give no result still pass through the extractor.
// Reset (rst_n low, synchronous) empties both stages and clears the extractor state.
`timescale 1ns / 1ps
module lsb_two_bit_extract
  import lbe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // slave side
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [CHAN_W-1:0]          in_tdata,   // [7:0] channel_byte
  input  logic                       in_tuser,   // [0] image_start
  // master side
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [LEN_W+PAYLOAD_W-1:0] out_tdata,  // [7:0] payload_byte, [39:8] announced_length
  output logic                       out_tuser,  // [0] result_kind
  output logic                       out_tlast   // last_byte
);

  logic  s1_valid;
  item_t s1_item;
  logic  obuf_full;
  logic  fire;       // held beat moves through the extractor this cycle
  logic  push;
  res_t  res;

  // A beat only advances when the result buffer has room, whether or not
  // it produces a result.
  assign fire = s1_valid && !obuf_full;

  lbe_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take_i    (fire),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  // header/payload state machine, one pair per beat
  lbe_extract u_ext (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (fire),
    .item_i (s1_item),
    .push_o (push),
    .res_o  (res)
  );

  lbe_out_buf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .res_i      (res),
    .full_o     (obuf_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sim/testbench.sv
// Testbench for lsb_two_bit_extract: self-checking stream test with a built-in predictor.
`timescale 1ns / 1ps
module testbench;
  import lbe_pkg::*;

  localparam int STALL_LIMIT = 4000;        // cycles with no beat on either side
  localparam int RANDOM_BEATS = 1240;       // live beats spread over the idling phases
  localparam longint WHOLE_IMAGE = 64'd1 << 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [CHAN_W-1:0]          in_tdata = '0;    // [7:0] channel_byte
  logic                       in_tuser = 1'b0;  // [0] image_start
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [LEN_W+PAYLOAD_W-1:0] out_tdata;        // [7:0] payload_byte, [39:8] announced_length
  logic                       out_tuser;        // [0] result_kind
  logic                       out_tlast;        // last_byte

  lsb_two_bit_extract u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;

  // run statistics
  int fail_count = 0;
  int live_beats = 0;
  int ignored_beats = 0;
  int images_started = 0;
  int headers_seen = 0;
  int zero_headers = 0;
  int bytes_seen = 0;

  // predicted extractor state
  logic [4:0]       hdr_pairs = '0;
  logic [31:0]      hdr_bits = '0;
  logic [31:0]      msg_len = '0;
  logic [5:0]       byte_bits = '0;
  logic [1:0]       byte_pairs = '0;
  logic [31:0]      bytes_out = '0;
  logic             msg_done = 1'b0;

  res_t pending_results[$];

  // Advance the extractor by one channel byte and queue any result it yields.
  task automatic extract_predict(input logic [7:0] chan, input logic start);
    res_t r;
    logic [1:0] pair;
    pair = chan[1:0];
    if (start) begin
      hdr_pairs = '0;
      hdr_bits = '0;
      msg_len = '0;
      byte_bits = '0;
      byte_pairs = '0;
      bytes_out = '0;
      msg_done = 1'b0;
      images_started++;
    end
    if (msg_done) begin
      ignored_beats++;
    end else begin
      live_beats++;
      if (hdr_pairs < HEADER_PAIRS) begin
        hdr_bits = {hdr_bits[29:0], pair};
        hdr_pairs = hdr_pairs + 5'd1;
        if (hdr_pairs == HEADER_PAIRS) begin
          msg_len = hdr_bits;
          r.kind = KIND_HEADER;
          r.payload = '0;
          r.length = msg_len;
          r.last = (msg_len == 32'd0);
          msg_done = r.last;  // zero length: nothing follows the header
          pending_results.push_back(r);
        end
      end else if (byte_pairs != LAST_PAIR_IN_BYTE) begin
        byte_bits = {byte_bits[3:0], pair};
        byte_pairs = byte_pairs + 2'd1;
      end else begin
        r.kind = KIND_PAYLOAD;
        r.payload = {byte_bits, pair};
        r.length = msg_len;
        byte_bits = '0;
        byte_pairs = '0;
        bytes_out = bytes_out + 32'd1;
        r.last = (bytes_out == msg_len);
        msg_done = r.last;
        pending_results.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t ERROR %s: expected %h, got %h", $time, fname, exp_v, got_v);
    end
  endtask

  // Compare one accepted result beat against the oldest prediction.
  task automatic check_result();
    res_t r;
    if (pending_results.size() == 0) begin
      fail_count++;
      $display("%0t ERROR unexpected result: expected none, got kind %b data %h last %b",
               $time, out_tuser, out_tdata, out_tlast);
    end else begin
      r = pending_results.pop_front();
      check_field("result_kind", 32'(r.kind), 32'(out_tuser));
      check_field("payload_byte", 32'(r.payload), 32'(out_tdata[PAYLOAD_W-1:0]));
      check_field("announced_length", r.length, out_tdata[LEN_W+PAYLOAD_W-1:PAYLOAD_W]);
      check_field("last_byte", 32'(r.last), 32'(out_tlast));
      if (r.kind == KIND_HEADER) begin
        headers_seen++;
        if (r.length == 32'd0) zero_headers++;
      end else begin
        bytes_seen++;
      end
    end
  endtask

  // Monitor: both sides sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) extract_predict(in_tdata, in_tuser);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // Receiver: long hold-off first, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck = 0;
      else stuck++;
    end
    $display("%0t ERROR: no beat accepted for %0d cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // One input beat; valid stays high afterwards until the next call or end_burst.
  task automatic send_beat(input logic [7:0] chan, input logic start);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= chan;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Bit pair in the low bits, noise in the upper six.
  task automatic send_pair(input logic [1:0] pair, input logic start);
    logic [7:0] chan;
    chan = 8'($urandom);
    chan[1:0] = pair;
    send_beat(chan, start);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Header for len, then its payload; stops early after max_beats beats.
  task automatic send_image(input logic [31:0] len, input longint max_beats);
    longint full;
    longint k;
    logic [7:0] pay;
    full = 16 + 4 * longint'(len);
    if (max_beats < full) full = max_beats;
    pay = 8'h00;
    for (k = 0; k < full; k++) begin
      if (k < 16) begin
        send_pair(len[2*(15-k) +: 2], k == 0);
      end else begin
        if ((k - 16) % 4 == 0) pay = pick_byte();
        send_pair(pay[2*(3-(k-16)%4) +: 2], 1'b0);
      end
    end
  endtask

  // Zero length: header carries last, following bytes are dropped.
  task automatic test_zero_length();
    send_image(32'd0, WHOLE_IMAGE);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    end_burst();
  endtask

  // All-ones header, a couple of payload bytes, then cut off by the next image.
  task automatic test_max_length();
    send_image(32'hFFFF_FFFF, 24);
    end_burst();
  endtask

  // Receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 250;
    send_image(32'd20, WHOLE_IMAGE);
    end_burst();
  endtask

  // Sender pauses until every result is out, then resumes.
  task automatic test_drain_pause();
    wait_drained();
    send_image(32'd3, WHOLE_IMAGE);
    end_burst();
    wait_drained();
  endtask

  // Mostly well-formed images with random content, plus cut images and noise.
  task automatic test_random(input int send_pct, input int recv_pct, input int beats);
    int goal;
    int pick;
    logic [31:0] len;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    goal = live_beats + beats;
    while (live_beats < goal) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        if ($urandom_range(29) == 0) begin
          send_image(32'($urandom), 16 + $urandom_range(48));
        end else begin
          len = ($urandom_range(9) == 0) ? 32'($urandom_range(40)) : 32'($urandom_range(12));
          send_image(len, WHOLE_IMAGE);
          repeat ($urandom_range(3)) send_beat(8'($urandom), 1'b0);
        end
      end else if (pick < 90) begin
        len = 32'($urandom_range(20));
        send_image(len, $urandom_range(1, 15 + 4 * len));
      end else begin
        repeat ($urandom_range(1, 6)) send_beat(8'($urandom), $urandom_range(3) == 0);
      end
    end
    end_burst();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_length();
    test_max_length();
    test_backpressure();
    test_drain_pause();
    test_random(0, 0, RANDOM_BEATS / 4);
    test_random(73, 0, RANDOM_BEATS / 4);
    test_random(0, 73, RANDOM_BEATS / 4);
    test_random(6, 6, RANDOM_BEATS / 4);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      fail_count++;
      $display("%0t ERROR: %0d results expected, none arrived", $time,
               pending_results.size());
    end

    $display("Run: %0d images, %0d live and %0d dropped channel bytes, %0d mismatches",
             images_started, live_beats, ignored_beats, fail_count);
    $display("Results: %0d length headers (%0d zero), %0d payload bytes",
             headers_seen, zero_headers, bytes_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/lbe_pkg.sv
rtl/lbe_in_stage.sv
rtl/lbe_extract.sv
rtl/lbe_out_buf.sv
rtl/lsb_two_bit_extract.sv
sim/testbench.sv
